FILE: src/id3p_pkg.sv
package id3p_pkg;

    localparam int TEXT_CAP = 64;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_FHDR    = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_DONE    = 3'd3,
        PH_STOPPED = 3'd4,
        PH_BAD     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_TITLE  = 3'd1,
        CL_ARTIST = 3'd2,
        CL_ALBUM  = 3'd3,
        CL_GENRE  = 3'd4,
        CL_YEAR   = 3'd5,
        CL_TRACK  = 3'd6,
        CL_ART    = 3'd7
    } t_class;

    localparam logic [2:0] K_TEXT  = 3'd0;
    localparam logic [2:0] K_TEND  = 3'd1;
    localparam logic [2:0] K_NUM   = 3'd2;
    localparam logic [2:0] K_ART   = 3'd3;
    localparam logic [2:0] K_TAG   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    localparam logic [28:0] COUNT_MAX = 29'h1FFF_FFFF;
    localparam logic [31:0] MAG_CAP   = 32'h8000_0000;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  field_sel;
        logic [5:0]  position;
        logic [7:0]  text_byte;
        logic [5:0]  text_length;
        logic [31:0] number_value;
        logic [28:0] art_offset;
        logic [27:0] art_size;
        logic [1:0]  status;
        logic        last_result;
    } t_result;

    function automatic t_class class3(input logic [23:0] w);
        case (w)
            24'h545432: class3 = CL_TITLE;
            24'h545031: class3 = CL_ARTIST;
            24'h54414C: class3 = CL_ALBUM;
            24'h54434F: class3 = CL_GENRE;
            24'h545945: class3 = CL_YEAR;
            24'h54524B: class3 = CL_TRACK;
            24'h504943: class3 = CL_ART;
            default:    class3 = CL_NONE;
        endcase
    endfunction

    function automatic t_class class4(input logic [31:0] w);
        case (w)
            32'h54495432: class4 = CL_TITLE;
            32'h54504531: class4 = CL_ARTIST;
            32'h54414C42: class4 = CL_ALBUM;
            32'h54434F4E: class4 = CL_GENRE;
            32'h54594552: class4 = CL_YEAR;
            32'h54445243: class4 = CL_YEAR;
            32'h5452434B: class4 = CL_TRACK;
            32'h41504943: class4 = CL_ART;
            default: class4 = (w[7:0] == 8'd0) ? class3(w[31:8]) : CL_NONE;
        endcase
    endfunction

    function automatic t_result res_zero();
        t_result r;
        r = '0;
        return r;
    endfunction

endpackage

FILE: src/id3p_out_queue.sv
// output queue: takes up to three results per cycle, drains one per transfer
module id3p_out_queue
    import id3p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_cnt,
    input  t_result    i_res [3],
    output logic       o_space,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);
    localparam int DEPTH = 8;

    t_result    r_mem [DEPTH];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt;
    logic       pop;
    logic [3:0] n_cnt;

    assign o_valid = (r_cnt != 4'd0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    // room for three more once the results being written this cycle are in
    assign o_space = ((r_cnt + {2'd0, i_cnt}) <= 4'd5);
    assign n_cnt   = r_cnt + {2'd0, i_cnt} - {3'd0, pop};

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + {1'b0, i_cnt};
            r_rp  <= r_rp + {2'd0, pop};
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(i_cnt)) begin
                r_mem[r_wp + 3'(k)] <= i_res[k];
            end
        end
    end
endmodule

FILE: src/id3v2_frame_parser.sv
// ID3v2 tag parser: one byte is taken per cycle while the result queue has room
// for three items beyond those of the byte in the input register; each byte
// yields up to three results (text bytes, field ends, numbers, picture location,
// tag end) which drain one per transfer from an eight-entry queue. Each byte passes
// through the input register and then the result queue before its results are shown.
module id3v2_frame_parser
    import id3p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_field_sel,
    output logic [5:0]  o_position,
    output logic [7:0]  o_text_byte,
    output logic [5:0]  o_text_length,
    output logic signed [31:0] o_number_value,
    output logic [28:0] o_art_offset,
    output logic [27:0] o_art_size,
    output logic [1:0]  o_status,
    output logic        o_last_result
);
    // input register
    logic       r_in_v, r_last;
    logic [7:0] r_b;
    logic       space, take;

    // parser state
    t_phase      r_phase, n_phase;
    logic [28:0] r_pos, n_pos;
    logic [31:0] r_hw, n_hw;
    logic [7:0]  r_ver, n_ver;
    logic [28:0] r_end, n_end;
    logic [31:0] r_rem, n_rem;
    t_class      r_cls, n_cls;
    logic [7:0]  r_enc, n_enc;
    logic [31:0] r_tc, n_tc;
    logic [5:0]  r_trim, n_trim;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_nph, n_nph;
    logic        r_neg, n_neg;
    logic        r_bom, n_bom;
    logic [3:0]  r_hi, n_hi;

    // results of this byte
    t_result    res [3];
    logic [1:0] cnt;

    assign take    = i_valid && o_ready;
    assign o_ready = space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= take;
        end
        if (take) begin
            r_b    <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // combinational step over one byte
    always_comb begin
        logic        wide;
        logic [3:0]  idlen, hlen;
        logic [32:0] startv;
        logic [7:0]  first;
        logic [31:0] r, ti, ki;
        logic        closing;
        logic [1:0]  st;
        logic [35:0] v;
        logic [31:0] nv;
        logic        digit, fed;
        t_result     e;
        n_phase = r_phase; n_pos = r_pos; n_hw = r_hw; n_ver = r_ver;
        n_end = r_end; n_rem = r_rem; n_cls = r_cls; n_enc = r_enc;
        n_tc = r_tc; n_trim = r_trim; n_acc = r_acc; n_nph = r_nph;
        n_neg = r_neg; n_bom = r_bom; n_hi = r_hi;
        res[0] = res_zero(); res[1] = res_zero(); res[2] = res_zero();
        cnt = 2'd0;
        wide  = (r_ver >= 8'd3);
        idlen = wide ? 4'd4 : 4'd3;
        hlen  = wide ? 4'd10 : 4'd6;
        startv = {4'd0, r_pos} + 33'd1;
        first = 8'd0; r = 32'd0; ti = 32'd0; ki = 32'd0;
        closing = 1'b0; st = ST_OK; v = '0; nv = '0; digit = 1'b0; fed = 1'b0;
        e = res_zero();
        if (r_in_v) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == 29'd0 && r_b != 8'h49) n_phase = PH_BAD;
                    else if (r_pos == 29'd1 && r_b != 8'h44) n_phase = PH_BAD;
                    else if (r_pos == 29'd2 && r_b != 8'h33) n_phase = PH_BAD;
                    else if (r_pos == 29'd3) n_ver = r_b;
                    else if (r_pos >= 29'd6) begin
                        n_rem = {r_rem[24:0], r_b[6:0]};
                        if (r_pos == 29'd9) begin
                            n_end = 29'd10 + {1'b0, n_rem[27:0]};
                            n_rem = '0;
                            if (29'd20 >= n_end) n_phase = PH_DONE;
                            else begin
                                n_phase = PH_FHDR; n_hi = '0; n_hw = '0;
                            end
                        end
                    end
                end
                PH_FHDR: begin
                    if (r_hi < idlen) n_hw = {r_hw[23:0], r_b};
                    else if (r_hi < 4'(2 * idlen)) begin
                        if (r_ver >= 8'd4) n_rem = {r_rem[24:0], r_b[6:0]};
                        else n_rem = {r_rem[23:0], r_b};
                    end
                    n_hi = r_hi + 4'd1;
                    if (n_hi >= hlen) begin
                        first = wide ? n_hw[31:24] : n_hw[23:16];
                        if (n_rem == 32'd0 || first == 8'd0 ||
                            {1'b0, startv} + {2'd0, n_rem} > {5'd0, r_end}) begin
                            n_phase = PH_STOPPED;
                        end else begin
                            n_cls = wide ? class4(n_hw) : class3(n_hw[23:0]);
                            if (n_cls == CL_ART) begin
                                e = res_zero();
                                e.kind = K_ART;
                                e.art_offset = startv[28:0];
                                e.art_size = n_rem[27:0];
                                res[0] = e; cnt = 2'd1;
                            end
                            n_phase = PH_PAYLOAD;
                            n_tc = '0; n_trim = '0; n_acc = '0; n_nph = '0;
                            n_neg = 1'b0; n_bom = 1'b0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r = r_rem;
                    n_rem = r - 32'd1;
                    if (r_tc == 32'd0) n_enc = r_b;
                    else begin
                        ti = r_tc - 32'd1;
                        if (ti == 32'd0 && (r_enc == 8'd1 || r_enc == 8'd2) &&
                            r >= 32'd2 && (r_b == 8'hFF || r_b == 8'hFE)) n_bom = 1'b1;
                        if (!(n_bom && ti < 32'd2)) begin
                            ki = n_bom ? ti - 32'd2 : ti;
                            if (r_cls >= CL_TITLE && r_cls <= CL_GENRE) begin
                                if (ki < 32'(TEXT_CAP - 1)) begin
                                    e = res_zero();
                                    e.kind = K_TEXT;
                                    e.field_sel = 3'(r_cls) - 3'd1;
                                    e.position = ki[5:0];
                                    e.text_byte = r_b;
                                    res[0] = e; cnt = 2'd1;
                                    if (r_b != 8'h20 && r_b != 8'h00)
                                        n_trim = ki[5:0] + 6'd1;
                                end
                            end else if (r_cls == CL_YEAR) begin
                                fed = (ki < 32'd4);
                            end else if (r_cls == CL_TRACK) begin
                                fed = 1'b1;
                            end
                        end
                    end
                    // atoi step
                    if (fed) begin
                        digit = (r_b >= 8'h30 && r_b <= 8'h39);
                        if (r_nph == 2'd0 && (r_b == 8'h20 ||
                            (r_b >= 8'd9 && r_b <= 8'd13))) begin
                            n_nph = r_nph;
                        end else if (r_nph == 2'd0 && (r_b == 8'h2B || r_b == 8'h2D)) begin
                            n_neg = (r_b == 8'h2D); n_nph = 2'd1;
                        end else if (r_nph == 2'd3) begin
                            n_nph = r_nph;
                        end else if (digit) begin
                            v = {r_acc, 3'd0} + {2'd0, r_acc, 1'b0} + {28'd0, r_b - 8'h30};
                            n_acc = (v > {4'd0, MAG_CAP}) ? MAG_CAP : v[31:0];
                            n_nph = 2'd2;
                        end else n_nph = 2'd3;
                    end
                    if (r_tc != 32'hFFFF_FFFF) n_tc = r_tc + 32'd1;
                    if (n_rem == 32'd0) begin
                        closing = 1'b1;
                        if ({4'd0, r_pos} + 33'd11 >= {4'd0, r_end}) n_phase = PH_DONE;
                        else begin
                            n_phase = PH_FHDR; n_hi = '0; n_hw = '0; n_rem = '0;
                        end
                    end
                end
                default: ;
            endcase
            // buffer ends with a field open, including one opened by this byte
            if (r_last && n_phase == PH_PAYLOAD) closing = 1'b1;
            // field close
            if (closing) begin
                e = res_zero();
                if (n_cls >= CL_TITLE && n_cls <= CL_GENRE) begin
                    e.kind = K_TEND;
                    e.field_sel = 3'(n_cls) - 3'd1;
                    e.text_length = n_trim;
                    res[cnt] = e; cnt = cnt + 2'd1;
                end else if (n_cls == CL_YEAR || n_cls == CL_TRACK) begin
                    if (n_neg) nv = 32'd0 - n_acc;
                    else nv = (n_acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_acc;
                    e.kind = K_NUM;
                    e.field_sel = (n_cls == CL_YEAR) ? 3'd4 : 3'd5;
                    e.number_value = nv;
                    res[cnt] = e; cnt = cnt + 2'd1;
                end
            end
            if (r_pos < COUNT_MAX) n_pos = r_pos + 29'd1;
            // tag end
            if (r_last) begin
                if (n_phase == PH_HEADER || n_phase == PH_BAD) st = ST_BAD;
                else if (n_phase == PH_DONE) st = ST_OK;
                else if (n_phase == PH_FHDR) st = (n_hi == 4'd0) ? ST_OK : ST_STOPPED;
                else st = ST_STOPPED;
                e = res_zero();
                e.kind = K_TAG;
                e.status = st;
                res[cnt] = e; cnt = cnt + 2'd1;
                n_phase = PH_HEADER; n_pos = '0; n_hw = '0; n_ver = '0; n_end = '0;
                n_rem = '0; n_cls = CL_NONE; n_enc = '0; n_tc = '0; n_trim = '0;
                n_acc = '0; n_nph = '0; n_neg = 1'b0; n_bom = 1'b0; n_hi = '0;
            end
            if (cnt != 2'd0) res[cnt - 2'd1].last_result = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_hw <= '0; r_ver <= '0; r_end <= '0;
            r_rem <= '0; r_cls <= CL_NONE; r_enc <= '0; r_tc <= '0; r_trim <= '0;
            r_acc <= '0; r_nph <= '0; r_neg <= 1'b0; r_bom <= 1'b0; r_hi <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_hw <= n_hw; r_ver <= n_ver;
            r_end <= n_end; r_rem <= n_rem; r_cls <= n_cls; r_enc <= n_enc;
            r_tc <= n_tc; r_trim <= n_trim; r_acc <= n_acc; r_nph <= n_nph;
            r_neg <= n_neg; r_bom <= n_bom; r_hi <= n_hi;
        end
    end

    t_result q;

    id3p_out_queue u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (cnt),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (q)
    );

    assign o_kind         = q.kind;
    assign o_field_sel    = q.field_sel;
    assign o_position     = q.position;
    assign o_text_byte    = q.text_byte;
    assign o_text_length  = q.text_length;
    assign o_number_value = q.number_value;
    assign o_art_offset   = q.art_offset;
    assign o_art_size     = q.art_size;
    assign o_status       = q.status;
    assign o_last_result  = q.last_result;
endmodule
